// File: hdl/bal_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list package
// Sizes, operation and status codes, and the structs that pass between the
// sequencer, the element RAM and the top level.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 9;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_EDIT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    read_value;
        logic [POS_W-1:0]    found_position;
        logic [TOTAL_W-1:0]  element_total;
        logic                is_empty;
        logic                is_full;
    } t_result;

endpackage

// File: hdl/bal_if.sv
// ----------------------------------------------------------------------------
// Bounded array list channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bal_req_if;
    logic                      valid;
    logic                      ready;
    logic [bal_pkg::FUNC_W-1:0] func;
    logic [bal_pkg::POS_W-1:0]  position;
    logic [bal_pkg::VAL_W-1:0]  item_value;

    modport source (output valid, func, position, item_value, input ready);
    modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface bal_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bal_pkg::STATUS_W-1:0] status;
    logic [bal_pkg::VAL_W-1:0]    read_value;
    logic [bal_pkg::POS_W-1:0]    found_position;
    logic [bal_pkg::TOTAL_W-1:0]  element_total;
    logic                         is_empty;
    logic                         is_full;

    modport source (output valid, status, read_value, found_position, element_total,
                    is_empty, is_full, input ready);
    modport sink   (input valid, status, read_value, found_position, element_total,
                    is_empty, is_full, output ready);
endinterface

// File: hdl/bal_ram.sv
// ----------------------------------------------------------------------------
// Bounded array list element RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bal_ram (
    input  logic                           i_clk,
    input  bal_pkg::t_ram_req              i_req,
    output logic [bal_pkg::DATA_WIDTH-1:0] o_rdata
);

    logic [bal_pkg::DATA_WIDTH-1:0] r_mem [bal_pkg::DEPTH];
    logic [bal_pkg::DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded array list sequencer
// Decodes one request, then walks the element RAM one word per cycle for
// shifts and searches, using a single read port, write port and comparator.
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bal_pkg::FUNC_W-1:0]     i_func,
    input  logic [bal_pkg::POS_W-1:0]      i_position,
    input  logic [bal_pkg::VAL_W-1:0]      i_item_value,
    output bal_pkg::t_ram_req              o_ram,
    input  logic [bal_pkg::DATA_WIDTH-1:0] i_rdata,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output bal_pkg::t_result               o_res
);

    localparam int AW = bal_pkg::ADDR_W;
    localparam int CW = bal_pkg::CNT_W;
    localparam int DW = bal_pkg::DATA_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SHIFT_UP, S_PUT, S_SHIFT_DN, S_FIND, S_GET_WAIT, S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [bal_pkg::FUNC_W-1:0]      r_func, n_func;
    logic [bal_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [DW-1:0]                   r_val, n_val;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_wpend, n_wpend;
    logic [AW-1:0]                   r_waddr, n_waddr;
    logic                            r_cmp_pend, n_cmp_pend;
    logic [AW-1:0]                   r_cmp_addr, n_cmp_addr;
    logic [bal_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [DW-1:0]                   r_rd, n_rd;
    logic [bal_pkg::POS_W-1:0]       r_fpos, n_fpos;

    logic [31:0] pos_x, cnt_x, idx_x;
    logic        full;

    assign pos_x = 32'(r_pos);
    assign cnt_x = 32'(r_count);
    assign idx_x = 32'(r_idx);
    assign full  = (cnt_x >= 32'(bal_pkg::DEPTH));

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_pos      = r_pos;
        n_val      = r_val;
        n_count    = r_count;
        n_idx      = r_idx;
        n_wpend    = r_wpend;
        n_waddr    = r_waddr;
        n_cmp_pend = r_cmp_pend;
        n_cmp_addr = r_cmp_addr;
        n_status   = r_status;
        n_rd       = r_rd;
        n_fpos     = r_fpos;
        o_ram      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func   = i_func;
                    n_pos    = i_position;
                    n_val    = DW'(i_item_value);
                    n_status = bal_pkg::ST_OK;
                    n_rd     = '0;
                    n_fpos   = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_func)
                    bal_pkg::FN_APPEND: begin
                        if (full) begin
                            n_status = bal_pkg::ST_FULL;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = AW'(r_count);
                            o_ram.wdata = r_val;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    bal_pkg::FN_INSERT: begin
                        if (full) begin
                            n_status = bal_pkg::ST_FULL;
                        end else if (pos_x > cnt_x) begin
                            n_status = bal_pkg::ST_BADIDX;
                        end else begin
                            n_idx   = r_count;
                            n_wpend = 1'b0;
                            n_state = S_SHIFT_UP;
                        end
                    end
                    bal_pkg::FN_DELETE: begin
                        if (r_count == '0) begin
                            n_status = bal_pkg::ST_EMPTY;
                        end else if (pos_x >= cnt_x) begin
                            n_status = bal_pkg::ST_BADIDX;
                        end else begin
                            n_idx   = CW'(r_pos);
                            n_wpend = 1'b0;
                            n_state = S_SHIFT_DN;
                        end
                    end
                    bal_pkg::FN_EDIT: begin
                        if (pos_x >= cnt_x) begin
                            n_status = bal_pkg::ST_BADIDX;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = AW'(r_pos);
                            o_ram.wdata = r_val;
                        end
                    end
                    bal_pkg::FN_GET: begin
                        if (pos_x >= cnt_x) begin
                            n_status = bal_pkg::ST_BADIDX;
                        end else begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = AW'(r_pos);
                            n_state     = S_GET_WAIT;
                        end
                    end
                    bal_pkg::FN_FIND: begin
                        n_idx      = '0;
                        n_cmp_pend = 1'b0;
                        n_state    = S_FIND;
                    end
                    default: begin
                        n_status = bal_pkg::ST_OK;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // The write of the word read last cycle overlaps the next read.
                o_ram.we    = r_wpend;
                o_ram.waddr = r_waddr;
                o_ram.wdata = i_rdata;
                if (idx_x > pos_x) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = AW'(r_idx - CW'(1));
                    n_waddr     = AW'(r_idx);
                    n_wpend     = 1'b1;
                    n_idx       = r_idx - CW'(1);
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = AW'(r_pos);
                o_ram.wdata = r_val;
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_SHIFT_DN: begin
                o_ram.we    = r_wpend;
                o_ram.waddr = r_waddr;
                o_ram.wdata = i_rdata;
                if (idx_x + 32'd1 < cnt_x) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = AW'(r_idx + CW'(1));
                    n_waddr     = AW'(r_idx);
                    n_wpend     = 1'b1;
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_wpend = 1'b0;
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                // Compare the word fetched last cycle while fetching the next.
                if (r_cmp_pend && (i_rdata == r_val)) begin
                    n_fpos   = bal_pkg::POS_W'(r_cmp_addr);
                    n_status = bal_pkg::ST_OK;
                    n_state  = S_DONE;
                end else if (idx_x < cnt_x) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = AW'(r_idx);
                    n_cmp_pend  = 1'b1;
                    n_cmp_addr  = AW'(r_idx);
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_status = bal_pkg::ST_NOTFOUND;
                    n_state  = S_DONE;
                end
            end
            S_GET_WAIT: begin
                n_rd    = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_wpend    <= 1'b0;
            r_cmp_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_wpend    <= n_wpend;
            r_cmp_pend <= n_cmp_pend;
        end
        r_func     <= n_func;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_waddr    <= n_waddr;
        r_cmp_addr <= n_cmp_addr;
        r_status   <= n_status;
        r_rd       <= n_rd;
        r_fpos     <= n_fpos;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status         = r_status;
        o_res.read_value     = bal_pkg::VAL_W'(r_rd);
        o_res.found_position = r_fpos;
        o_res.element_total  = bal_pkg::TOTAL_W'(r_count);
        o_res.is_empty       = (r_count == '0);
        o_res.is_full        = full;
    end

endmodule

// File: hdl/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded array list engine
// Dense ordered list with append, insert, delete, edit, get and find.
// ----------------------------------------------------------------------------
// One request is taken at a time and the request port stays not ready until
// its work is done; a finished response waits in an output register, so the
// next request can be taken while the response is still pending. Append,
// edit, rejected requests and undefined codes finish in the execute state,
// get adds a registered RAM read, insert shifts the words from the end down
// to the position up by one and then writes the item, delete shifts the
// words after the position down by one, and find reads words in order until
// a match or the end. The RAM gives a read and a write per cycle: shifts and
// searches move one word per cycle. Elements need no clearing after reset.
module bounded_array_list_engine (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bal_req_if.sink  i_req,
    bal_rsp_if.source o_rsp
);

    bal_pkg::t_ram_req              ram_req;
    logic [bal_pkg::DATA_WIDTH-1:0] ram_rdata;
    logic                           res_valid;
    logic                           res_ready;
    bal_pkg::t_result               res;

    logic             r_rsp_valid;
    bal_pkg::t_result r_rsp;

    bal_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_func       (i_req.func),
        .i_position   (i_req.position),
        .i_item_value (i_req.item_value),
        .o_ram        (ram_req),
        .i_rdata      (ram_rdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    bal_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_rsp_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (res_ready) begin
            r_rsp_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_rsp <= res;
        end
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.status         = r_rsp.status;
    assign o_rsp.read_value     = r_rsp.read_value;
    assign o_rsp.found_position = r_rsp.found_position;
    assign o_rsp.element_total  = r_rsp.element_total;
    assign o_rsp.is_empty       = r_rsp.is_empty;
    assign o_rsp.is_full        = r_rsp.is_full;

endmodule

// File: hdl/bal_checker.sv
// ----------------------------------------------------------------------------
// Bounded array list checker
// Port-level assertions on the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bal_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [bal_pkg::STATUS_W-1:0] i_status,
    input logic [bal_pkg::VAL_W-1:0]    i_read_value,
    input logic [bal_pkg::TOTAL_W-1:0]  i_element_total,
    input logic                         i_is_empty,
    input logic                         i_is_full
);

    // A stalled response transaction stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_is_empty == (i_element_total == '0)))
        else $error("empty flag disagrees with element total");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_is_full ==
            (i_element_total == bal_pkg::TOTAL_W'(bal_pkg::DEPTH))))
        else $error("full flag disagrees with element total");

    // A failed request never returns read data.
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != bal_pkg::ST_OK) |-> (i_read_value == '0))
        else $error("read data returned with an error status");

endmodule

bind bounded_array_list_engine bal_checker u_bal_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_read_value    (o_rsp.read_value),
    .i_element_total (o_rsp.element_total),
    .i_is_empty      (o_rsp.is_empty),
    .i_is_full       (o_rsp.is_full)
);
